// File: rtl/core/iac_pkg.sv
// Shared request, result and match types and address range constants for the classifier.
package iac_pkg;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic        addr_is_v6;
    } addr_req_t;

    typedef struct packed {
        logic        routable;
        logic        local_res;
        logic        private_net;
        logic        loopback;
        logic        family_after_map;
        logic [31:0] netgroup_key;
        logic        rfc1918;
        logic        benchmark_range;
        logic        documentation;
        logic        shared_cgnat;
        logic        nat64_prefix;
        logic        tunnel_prefix;
    } class_res_t;

    typedef struct packed {
        logic        use_v4;
        logic        v4_lb;
        logic        v4_r1918;
        logic        v4_cgnat;
        logic        v4_llocal;
        logic        v4_bench;
        logic        v4_doc;
        logic        v4_ietf;
        logic        v4_mcast;
        logic        v4_resv;
        logic [15:0] v4_key;
        logic        v6_zero;
        logic        v6_lb;
        logic        v6_ll10;
        logic        v6_ll64;
        logic        v6_ula;
        logic        v6_mcast;
        logic        v6_doc;
        logic        v6_teredo;
        logic        v6_sixto4;
        logic        v6_orchid;
        logic        v6_orchid2;
        logic        v6_nat64;
        logic [31:0] v6_key;
    } range_match_t;

    localparam logic [31:0] V4_MAPPED_TAG  = 32'h0000_ffff;
    localparam logic [3:0]  V4_MCAST_NIB   = 4'he;
    localparam logic [3:0]  V4_RESV_NIB    = 4'hf;
    localparam logic [63:0] V6_LL64_HI     = 64'hfe80_0000_0000_0000;
    localparam logic [63:0] V6_NAT64_HI    = 64'h0064_ff9b_0000_0000;
    localparam logic [31:0] V6_DOC_W0      = 32'h2001_0db8;
    localparam logic [31:0] V6_TEREDO_W0   = 32'h2001_0000;
    localparam logic [15:0] V6_SIXTO4_P16  = 16'h2002;
    localparam logic [27:0] V6_ORCHID_P28  = 28'h2001_001;
    localparam logic [27:0] V6_ORCHID2_P28 = 28'h2001_002;

endpackage

// File: rtl/core/ip_address_classifier_unit.sv
// Top level of the IP address special-range classifier pipeline.
//
// Usage:
//   s_valid / s_ready / s_req carry one address request (IPv4 in addr_lo[31:0],
//   or IPv6 across addr_hi and addr_lo). m_valid / m_ready / m_res return one
//   classification result for every request, in request order.
// Path: from acceptance to m_valid, a request passes through the input register,
//   the range-match register and the output register.
// Throughput: one request per cycle, sustained while m_ready stays high; each
//   of the three stages holds one request.
// Reset: aresetn low at a clock edge empties all three stages; no result is
//   shown until a new request arrives.
// Stall: with m_ready low the result holds; earlier stages keep accepting
//   until each is full, then s_ready drops. No request is lost or repeated.
module ip_address_classifier_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iac_pkg::addr_req_t  s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output iac_pkg::class_res_t m_res
);
    import iac_pkg::*;

    logic         valid0_reg, valid0_next;
    logic         valid1_reg, valid1_next;
    logic         valid2_reg, valid2_next;
    logic         ready0, ready1, ready2;
    addr_req_t    data0_reg, data0_next;
    range_match_t match_comb;
    range_match_t data1_reg, data1_next;
    class_res_t   res_comb;
    class_res_t   data2_reg, data2_next;

    assign ready2  = !valid2_reg || m_ready;
    assign ready1  = !valid1_reg || ready2;
    assign ready0  = !valid0_reg || ready1;
    assign s_ready = ready0;
    assign m_valid = valid2_reg;
    assign m_res   = data2_reg;

    iac_range_match u_match (
        .req   (data0_reg),
        .match (match_comb)
    );

    always_comb begin
        res_comb = '0;
        if (data1_reg.use_v4) begin
            res_comb.routable        = !(data1_reg.v4_lb || data1_reg.v4_r1918 ||
                                         data1_reg.v4_cgnat || data1_reg.v4_llocal ||
                                         data1_reg.v4_bench || data1_reg.v4_doc ||
                                         data1_reg.v4_ietf || data1_reg.v4_mcast ||
                                         data1_reg.v4_resv);
            res_comb.local_res       = data1_reg.v4_lb || data1_reg.v4_llocal;
            res_comb.private_net     = data1_reg.v4_r1918 || data1_reg.v4_cgnat;
            res_comb.loopback        = data1_reg.v4_lb;
            res_comb.family_after_map = 1'b0;
            res_comb.netgroup_key    = data1_reg.v4_lb ? 32'd0 : {16'd0, data1_reg.v4_key};
            res_comb.rfc1918         = data1_reg.v4_r1918;
            res_comb.benchmark_range = data1_reg.v4_bench;
            res_comb.documentation   = data1_reg.v4_doc;
            res_comb.shared_cgnat    = data1_reg.v4_cgnat;
        end else begin
            res_comb.routable        = !(data1_reg.v6_zero || data1_reg.v6_lb ||
                                         data1_reg.v6_ll10 || data1_reg.v6_ula ||
                                         data1_reg.v6_mcast || data1_reg.v6_doc ||
                                         data1_reg.v6_teredo || data1_reg.v6_sixto4 ||
                                         data1_reg.v6_orchid || data1_reg.v6_orchid2);
            res_comb.local_res       = data1_reg.v6_lb || data1_reg.v6_ll64;
            res_comb.private_net     = data1_reg.v6_ula || data1_reg.v6_ll64 ||
                                       data1_reg.v6_teredo || data1_reg.v6_orchid;
            res_comb.loopback        = data1_reg.v6_lb;
            res_comb.family_after_map = 1'b1;
            res_comb.netgroup_key    = data1_reg.v6_lb ? 32'd0 : data1_reg.v6_key;
            res_comb.documentation   = data1_reg.v6_doc;
            res_comb.nat64_prefix    = data1_reg.v6_nat64;
            res_comb.tunnel_prefix   = data1_reg.v6_sixto4 || data1_reg.v6_teredo;
        end
    end

    always_comb begin
        valid0_next = valid0_reg;
        valid1_next = valid1_reg;
        valid2_next = valid2_reg;
        data0_next  = data0_reg;
        data1_next  = data1_reg;
        data2_next  = data2_reg;
        if (ready0) begin
            valid0_next = s_valid;
            data0_next  = s_req;
        end
        if (ready1) begin
            valid1_next = valid0_reg;
            data1_next  = match_comb;
        end
        if (ready2) begin
            valid2_next = valid1_reg;
            data2_next  = res_comb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            valid0_reg <= valid0_next;
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
        end
    end

    always_ff @(posedge aclk) begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
        data2_reg <= data2_next;
    end

endmodule

// File: rtl/core/iac_range_match.sv
// Prefix and range compares of one address for both address families.
module iac_range_match (
    input  iac_pkg::addr_req_t    req,
    output iac_pkg::range_match_t match
);
    import iac_pkg::*;

    logic [31:0] a4;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [31:0] w0;
    logic        mapped;

    assign a4     = req.addr_lo[31:0];
    assign b0     = a4[31:24];
    assign b1     = a4[23:16];
    assign b2     = a4[15:8];
    assign w0     = req.addr_hi[63:32];
    assign mapped = (req.addr_hi == 64'd0) && (req.addr_lo[63:32] == V4_MAPPED_TAG);

    always_comb begin
        match.use_v4    = !req.addr_is_v6 || mapped;
        match.v4_lb     = (b0 == 8'd127) || (b0 == 8'd0);
        match.v4_r1918  = (b0 == 8'd10) || ((b0 == 8'd172) && (b1[7:4] == 4'h1)) ||
                          ((b0 == 8'd192) && (b1 == 8'd168));
        match.v4_cgnat  = (b0 == 8'd100) && (b1[7:6] == 2'b01);
        match.v4_llocal = (b0 == 8'd169) && (b1 == 8'd254);
        match.v4_bench  = (b0 == 8'd198) && (b1[7:1] == 7'd9);
        match.v4_doc    = ((b0 == 8'd192) && (b1 == 8'd0) && (b2 == 8'd2)) ||
                          ((b0 == 8'd198) && (b1 == 8'd51) && (b2 == 8'd100)) ||
                          ((b0 == 8'd203) && (b1 == 8'd0) && (b2 == 8'd113));
        match.v4_ietf   = (b0 == 8'd192) && (b1 == 8'd0) && (b2 == 8'd0);
        match.v4_mcast  = (b0[7:4] == V4_MCAST_NIB);
        match.v4_resv   = (b0[7:4] == V4_RESV_NIB);
        match.v4_key    = {b0, b1};

        match.v6_zero    = (req.addr_hi == 64'd0) && (req.addr_lo == 64'd0);
        match.v6_lb      = (req.addr_hi == 64'd0) && (req.addr_lo == 64'd1);
        match.v6_ll10    = (w0[31:24] == 8'hfe) && (w0[23:22] == 2'b10);
        match.v6_ll64    = (req.addr_hi == V6_LL64_HI);
        match.v6_ula     = (w0[31:25] == 7'h7e);
        match.v6_mcast   = (w0[31:24] == 8'hff);
        match.v6_doc     = (w0 == V6_DOC_W0);
        match.v6_teredo  = (w0 == V6_TEREDO_W0);
        match.v6_sixto4  = (w0[31:16] == V6_SIXTO4_P16);
        match.v6_orchid  = (w0[31:4] == V6_ORCHID_P28);
        match.v6_orchid2 = (w0[31:4] == V6_ORCHID2_P28);
        match.v6_nat64   = (req.addr_hi == V6_NAT64_HI) && (req.addr_lo[63:32] == 32'd0);
        match.v6_key     = w0;
    end

endmodule

// File: rtl/core/iac_checker.sv
// Port-level checker for the classifier and its bind to the top level.
module iac_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input iac_pkg::class_res_t m_res
);
    import iac_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_loopback_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.loopback |-> m_res.netgroup_key == 32'd0)
        else $error("loopback result with nonzero netgroup key");

    a_v4_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_res.family_after_map |->
            !m_res.nat64_prefix && !m_res.tunnel_prefix && m_res.netgroup_key[31:16] == 16'd0)
        else $error("IPv4 result carries IPv6-only fields");

    a_routable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.routable |->
            !m_res.loopback && !m_res.local_res && !m_res.private_net &&
            !m_res.rfc1918 && !m_res.benchmark_range && !m_res.documentation &&
            !m_res.shared_cgnat && !m_res.tunnel_prefix)
        else $error("routable result also flagged as special range");

endmodule

bind ip_address_classifier_unit iac_checker u_iac_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);
